@@ sv/salc_pkg.sv @@
package salc_pkg;

  // Default sizes
  localparam int MaxSetsDef    = 64;
  localparam int MaxWaysDef    = 8;
  localparam int AddrWidthDef  = 64;
  localparam int QueueDepthDef = 2;

  // Configuration register widths
  localparam int SetBitsW   = 3;
  localparam int BlockBitsW = 5;
  localparam int WaysW      = 4;
  localparam int CfgDataW   = 5;
  localparam int CfgIdxW    = 2;

  // Raw set field: at most 7 address bits select the set
  localparam int SetRawW = 7;
  localparam int SetRawN = 128;

  localparam int StampW = 32;
  localparam int CntW   = 32;

  localparam logic [SetBitsW-1:0]   SetBitsRst   = 3'd4;
  localparam logic [BlockBitsW-1:0] BlockBitsRst = 5'd4;
  localparam logic [WaysW-1:0]      WaysRst      = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EVAL  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [1:0]      hits_now;
    logic            missed;
    logic            evicted;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] evict_total;
  } result_t;

endpackage

@@ sv/salc_fifo.sv @@
module salc_fifo import salc_pkg::*; #(
  parameter int Width  = 1,
  parameter int Depth  = QueueDepthDef,
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CountW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0]  store_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push_ok, pop_ok;

  assign full_o  = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CountW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/salc_front.sv @@
module salc_front import salc_pkg::*; #(
  parameter int MaxSets   = MaxSetsDef,
  parameter int MaxWays   = MaxWaysDef,
  parameter int AddrWidth = AddrWidthDef,
  localparam int SetW     = (MaxSets > 1) ? $clog2(MaxSets) : 1,
  localparam int WayCntW  = $clog2(MaxWays + 1),
  localparam int ReqW     = 1 + WayCntW + SetW + AddrWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 push_i,
  input  logic [1:0]           cmd_i,
  input  logic [AddrWidth-1:0] address_i,
  input  logic                 req_full_i,
  input  logic                 clearing_i,
  output logic                 full_o,
  output logic                 req_push_o,
  output logic [ReqW-1:0]      req_data_o
);

  localparam int MaskW  = SetRawW + 1;
  localparam int ShiftW = BlockBitsW + 1;

  // Reduce a raw set field into the set range
  function automatic logic [SetRawN*SetW-1:0] build_mod_tbl();
    logic [SetRawN*SetW-1:0] tbl;
    int r;
    tbl = '0;
    r   = 0;
    for (int i = 0; i < SetRawN; i++) begin
      tbl[i*SetW +: SetW] = SetW'(r);
      r = (r + 1 == MaxSets) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam logic [SetRawN*SetW-1:0] ModTbl = build_mod_tbl();

  logic [SetBitsW-1:0]   set_bits_q;
  logic [BlockBitsW-1:0] block_bits_q;
  logic [WaysW-1:0]      ways_q;

  logic [AddrWidth-1:0] shifted;
  logic [MaskW-1:0]     set_mask;
  logic [SetRawW-1:0]   set_raw;
  logic [SetW-1:0]      set_idx;
  logic [ShiftW-1:0]    tag_shift;
  logic [AddrWidth-1:0] tag;
  logic [WayCntW-1:0]   ways_eff;
  logic                 modify;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SetBitsRst;
      block_bits_q <= BlockBitsRst;
      ways_q       <= WaysRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SetBitsW-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BlockBitsW-1:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[WaysW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shifted   = address_i >> block_bits_q;
    set_mask  = (MaskW'(1) << set_bits_q) - MaskW'(1);
    set_raw   = shifted[SetRawW-1:0] & set_mask[SetRawW-1:0];
    set_idx   = ModTbl[set_raw * SetW +: SetW];
    tag_shift = ShiftW'(block_bits_q) + ShiftW'(set_bits_q);
    tag       = address_i >> tag_shift;
    if (ways_q == '0) begin
      ways_eff = WayCntW'(1);
    end else if (32'(ways_q) > 32'(MaxWays)) begin
      ways_eff = WayCntW'(MaxWays);
    end else begin
      ways_eff = WayCntW'(ways_q);
    end
    modify = (cmd_e'(cmd_i) == CMD_MODIFY);
  end

  assign full_o     = req_full_i | clearing_i;
  assign req_push_o = push_i & ~full_o;
  assign req_data_o = {modify, ways_eff, set_idx, tag};

endmodule

@@ sv/salc_back.sv @@
module salc_back import salc_pkg::*; #(
  parameter int MaxSets   = MaxSetsDef,
  parameter int MaxWays   = MaxWaysDef,
  parameter int AddrWidth = AddrWidthDef,
  localparam int SetW     = (MaxSets > 1) ? $clog2(MaxSets) : 1,
  localparam int WayCntW  = $clog2(MaxWays + 1),
  localparam int ReqW     = 1 + WayCntW + SetW + AddrWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_empty_i,
  input  logic [ReqW-1:0] req_data_i,
  output logic            req_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output result_t         res_o,
  output logic            clearing_o
);

  localparam int WayW   = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int EntryW = 1 + AddrWidth + StampW;
  localparam int RowW   = MaxWays * EntryW;
  localparam int LeafN  = 1 << $clog2(MaxWays);

  back_state_e state_q, state_d;
  logic [SetW-1:0] clr_q, clr_d;

  logic [RowW-1:0] mem [MaxSets];
  logic [RowW-1:0] rdata_q;
  logic [ReqW-1:0] req_q;

  logic [StampW-1:0] clock_q, clock_d;
  logic [CntW-1:0]   hit_q, hit_d;
  logic [CntW-1:0]   miss_q, miss_d;
  logic [CntW-1:0]   evict_q, evict_d;

  // Head of the request queue
  logic [SetW-1:0]      head_set;

  // Request under evaluation
  logic                 mod_r;
  logic [WayCntW-1:0]   ways_r;
  logic [SetW-1:0]      set_r;
  logic [AddrWidth-1:0] tag_r;

  logic                 start;
  logic                 mem_we;
  logic [SetW-1:0]      mem_waddr;
  logic [RowW-1:0]      mem_wdata;

  logic [MaxWays-1:0]   way_valid;
  logic [AddrWidth-1:0] way_tag   [MaxWays];
  logic [StampW-1:0]    way_stamp [MaxWays];
  logic [MaxWays-1:0]   in_use;
  logic [MaxWays-1:0]   match;
  logic                 hit;
  logic [WayW-1:0]      hit_way;
  logic                 have_empty;
  logic [WayW-1:0]      empty_way;
  logic                 evict;
  logic [WayW-1:0]      victim;
  logic [EntryW-1:0]    new_entry;
  logic [RowW-1:0]      new_row;
  logic [1:0]           hit_inc;

  // LRU search tree, root at node 1
  logic                 nd_ok    [2*LeafN];
  logic [StampW-1:0]    nd_stamp [2*LeafN];
  logic [WayW-1:0]      nd_idx   [2*LeafN];

  assign head_set                      = req_data_i[AddrWidth +: SetW];
  assign {mod_r, ways_r, set_r, tag_r} = req_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SetW'(MaxSets - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (!req_empty_i && !res_full_i) state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    start      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = set_r;
    mem_wdata  = new_row;
    res_push_o = 1'b0;
    clearing_o = 1'b0;
    clr_d      = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        mem_we     = 1'b1;
        mem_waddr  = clr_q;
        mem_wdata  = '0;
        clr_d      = clr_q + SetW'(1);
      end
      ST_IDLE: begin
        start = ~req_empty_i & ~res_full_i;
      end
      ST_EVAL: begin
        mem_we     = 1'b1;
        res_push_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign req_pop_o = start;

  // Lookup on the registered set row
  always_comb begin
    hit_way    = '0;
    empty_way  = '0;
    have_empty = 1'b0;
    for (int w = 0; w < MaxWays; w++) begin
      way_valid[w] = rdata_q[w*EntryW + EntryW - 1];
      way_tag[w]   = rdata_q[w*EntryW + StampW +: AddrWidth];
      way_stamp[w] = rdata_q[w*EntryW +: StampW];
      in_use[w]    = (32'(w) < 32'(ways_r));
      match[w]     = in_use[w] & way_valid[w] & (way_tag[w] == tag_r);
    end
    // Lowest matching way wins
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WayW'(w);
    end
    // Highest empty way wins
    for (int w = 0; w < MaxWays; w++) begin
      if (in_use[w] && !way_valid[w]) begin
        have_empty = 1'b1;
        empty_way  = WayW'(w);
      end
    end
    hit = |match;

    for (int n = 0; n < 2*LeafN; n++) begin
      nd_ok[n]    = 1'b0;
      nd_stamp[n] = '0;
      nd_idx[n]   = '0;
    end
    for (int w = 0; w < MaxWays; w++) begin
      nd_ok[LeafN + w]    = in_use[w] & way_valid[w];
      nd_stamp[LeafN + w] = way_stamp[w];
      nd_idx[LeafN + w]   = WayW'(w);
    end
    // Keep the left child on ties so the lower way wins
    for (int n = LeafN - 1; n >= 1; n--) begin
      if (nd_ok[2*n] && (!nd_ok[2*n+1] || nd_stamp[2*n] <= nd_stamp[2*n+1])) begin
        nd_ok[n]    = 1'b1;
        nd_stamp[n] = nd_stamp[2*n];
        nd_idx[n]   = nd_idx[2*n];
      end else begin
        nd_ok[n]    = nd_ok[2*n+1];
        nd_stamp[n] = nd_stamp[2*n+1];
        nd_idx[n]   = nd_idx[2*n+1];
      end
    end

    evict = ~hit & ~have_empty;
    if (hit) begin
      victim = hit_way;
    end else if (have_empty) begin
      victim = empty_way;
    end else begin
      victim = nd_idx[1];
    end

    clock_d   = clock_q + StampW'(1);
    new_entry = {1'b1, tag_r, clock_d};
    new_row   = rdata_q;
    for (int w = 0; w < MaxWays; w++) begin
      if (WayW'(w) == victim) new_row[w*EntryW +: EntryW] = new_entry;
    end

    // A modify's second lookup always hits the line just touched
    hit_inc = {1'b0, hit} + {1'b0, mod_r};
    hit_d   = hit_q + CntW'(hit_inc);
    miss_d  = miss_q + CntW'(!hit);
    evict_d = evict_q + CntW'(evict);
  end

  assign res_o = '{
    hits_now:    hit_inc,
    missed:      ~hit,
    evicted:     evict,
    hit_total:   hit_d,
    miss_total:  miss_d,
    evict_total: evict_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      clock_q <= '0;
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == ST_EVAL) begin
        clock_q <= clock_d;
        hit_q   <= hit_d;
        miss_q  <= miss_d;
        evict_q <= evict_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (start) begin
      rdata_q <= mem[head_set];
      req_q   <= req_data_i;
    end
  end

endmodule

@@ sv/set_assoc_lru_cache_sim.sv @@
// Channel  | Direction | Handshake        | Word
// ---------+-----------+------------------+----------------------------------------
// access   | in        | push / full      | cmd_i, address_i
// result   | out       | pop / empty      | hits_now_o, missed_o, evicted_o, totals
// config   | in        | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// In the lookup engine an access first reads the set's row from the line memory into a
// register, then compares, picks the victim and writes the row back in ST_EVAL.
// A modify needs no second pass; its second lookup always hits the same line.
// After reset the line memory is cleared one set per cycle, all MaxSets sets,
// with full held high; config writes are taken throughout.
// Two-word queues sit before and after the lookup engine, so each side stalls on its own.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int MaxSets   = MaxSetsDef,
  parameter int MaxWays   = MaxWaysDef,
  parameter int AddrWidth = AddrWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Access words
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           cmd_i,
  input  logic [AddrWidth-1:0] address_i,
  // Result words
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           hits_now_o,
  output logic                 missed_o,
  output logic                 evicted_o,
  output logic [CntW-1:0]      hit_total_o,
  output logic [CntW-1:0]      miss_total_o,
  output logic [CntW-1:0]      evict_total_o
);

  localparam int SetW    = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int WayCntW = $clog2(MaxWays + 1);
  localparam int ReqW    = 1 + WayCntW + SetW + AddrWidth;

  logic            req_push, req_full, req_pop, req_empty;
  logic [ReqW-1:0] req_wdata, req_rdata;
  logic            clearing;
  logic            res_push, res_full;
  result_t         res_wdata, res_rdata;

  // Front: hold the config, split the address into set and tag
  salc_front #(
    .MaxSets   (MaxSets),
    .MaxWays   (MaxWays),
    .AddrWidth (AddrWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .cmd_i      (cmd_i),
    .address_i  (address_i),
    .req_full_i (req_full),
    .clearing_i (clearing),
    .full_o     (full),
    .req_push_o (req_push),
    .req_data_o (req_wdata)
  );

  // Decoupling queue between classify and lookup
  salc_fifo #(
    .Width (ReqW),
    .Depth (QueueDepthDef)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .data_i  (req_wdata),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .data_o  (req_rdata),
    .empty_o (req_empty)
  );

  // Back: read set row, compare, fill an empty way or replace LRU, write back, count
  salc_back #(
    .MaxSets   (MaxSets),
    .MaxWays   (MaxWays),
    .AddrWidth (AddrWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_empty_i (req_empty),
    .req_data_i  (req_rdata),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wdata),
    .clearing_o  (clearing)
  );

  // Result queue; hold the oldest word on the ports until popped
  salc_fifo #(
    .Width ($bits(result_t)),
    .Depth (QueueDepthDef)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign hits_now_o    = res_rdata.hits_now;
  assign missed_o      = res_rdata.missed;
  assign evicted_o     = res_rdata.evicted;
  assign hit_total_o   = res_rdata.hit_total;
  assign miss_total_o  = res_rdata.miss_total;
  assign evict_total_o = res_rdata.evict_total;

endmodule

@@ sv/salc_checker.sv @@
module salc_checker import salc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            empty,
  input logic            pop,
  input logic [1:0]      hits_now_o,
  input logic            missed_o,
  input logic            evicted_o,
  input logic [CntW-1:0] hit_total_o,
  input logic [CntW-1:0] miss_total_o,
  input logic [CntW-1:0] evict_total_o
);

  logic [CntW-1:0] last_hit_q, last_miss_q, last_evict_q;
  logic            take;

  assign take = pop & ~empty;

  // Track the totals of the last word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hit_q   <= '0;
      last_miss_q  <= '0;
      last_evict_q <= '0;
    end else if (take) begin
      last_hit_q   <= hit_total_o;
      last_miss_q  <= miss_total_o;
      last_evict_q <= evict_total_o;
    end
  end

  a_hit_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> hit_total_o == last_hit_q + CntW'(hits_now_o))
    else $error("hit total does not follow hits of this word");

  a_miss_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> miss_total_o == last_miss_q + CntW'(missed_o))
    else $error("miss total does not follow miss of this word");

  a_evict_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> evict_total_o == last_evict_q + CntW'(evicted_o))
    else $error("eviction total does not follow eviction of this word");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && evicted_o |-> missed_o)
    else $error("eviction reported without a miss");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(hit_total_o) && $stable(miss_total_o))
    else $error("waiting result word changed");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
